### sv/lrba_pkg.sv
// ----------------------------------------------------------------------------
// lrba_pkg
// Shared types, constants and helper functions of the led ring band animator.
// ----------------------------------------------------------------------------
package lrba_pkg;

  // ring geometry defaults
  localparam int RING_PIXELS_DEFAULT = 16;
  localparam int BAND_SPAN_DEFAULT   = 11;

  // intensity range
  localparam int LEVEL_MAX   = 255;
  localparam int LEVEL_MIN   = 32;
  localparam int LEVEL_RESET = 128;

  // band centres after reset
  localparam int RED_CENTRE_RESET   = 0;
  localparam int GREEN_CENTRE_RESET = 4;
  localparam int BLUE_CENTRE_RESET  = 8;

  // tick offset and period registers
  localparam int OFF_W           = 6;
  localparam int CFG_W           = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CYCLE_RESET     = 50;
  localparam int RED_PER_RESET   = 25;
  localparam int GREEN_PER_RESET = 20;
  localparam int BLUE_PER_RESET  = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_PERIOD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_REVERSE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_REVERSE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_REVERSE  = 3'd6;

  typedef struct packed {
    logic dimmer_pressed;
    logic brighter_pressed;
  } lrba_tick_t;

  typedef struct packed {
    logic [3:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } lrba_pixel_t;

  // frame request from the tick logic to the pixel generator
  typedef struct packed {
    logic       bar;
    logic [7:0] level;
  } lrba_job_t;

  // level at ring distance gap: x / (gap + 1), by reciprocal multiply
  function automatic logic [7:0] lrba_band_level(input logic [7:0] x,
                                                 input logic [2:0] gap);
    logic [16:0] prod3;
    logic [16:0] prod5;
    logic [7:0]  res;
    prod3 = 17'(x) * 17'(171);
    prod5 = 17'(x) * 17'(205);
    case (gap)
      3'd0:    res = x;
      3'd1:    res = x >> 1;
      3'd2:    res = 8'(prod3 >> 9);
      3'd3:    res = x >> 2;
      3'd4:    res = 8'(prod5 >> 10);
      3'd5:    res = 8'(prod3 >> 10);
      default: res = 8'd0;
    endcase
    return res;
  endfunction

  // one restoring step of offset modulo period; a zero period keeps the offset
  function automatic logic [OFF_W-1:0] lrba_rem_step(input logic [OFF_W-1:0] rem,
                                                     input logic             bit_in,
                                                     input logic [OFF_W-1:0] period);
    logic [OFF_W:0] t;
    t = {rem, bit_in};
    if (period != '0 && t >= {1'b0, period}) begin
      t = t - {1'b0, period};
    end
    return t[OFF_W-1:0];
  endfunction

endpackage

### sv/lrba_tick_state.sv
// ----------------------------------------------------------------------------
// lrba_tick_state
// Configuration registers, button edge logic, intensity, tick offset, band
// phases and centres; hands a frame request to the pixel generator.
// ----------------------------------------------------------------------------
module lrba_tick_state
  import lrba_pkg::*;
#(
  parameter int RING_PIXELS = RING_PIXELS_DEFAULT,
  localparam int IW = $clog2(RING_PIXELS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick_valid,
  output logic                 tick_ready,
  input  lrba_tick_t           tick,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 job_valid,
  input  logic                 job_ready,
  output lrba_job_t            job,
  output logic [IW-1:0]        job_red_centre,
  output logic [IW-1:0]        job_green_centre,
  output logic [IW-1:0]        job_blue_centre
);

  localparam int STEP = (LEVEL_MAX - LEVEL_MIN) / RING_PIXELS;
  localparam int SYNC_W = $clog2(OFF_W + 1);

  logic [OFF_W-1:0] cycle_length;
  logic [OFF_W-1:0] red_period;
  logic [OFF_W-1:0] green_period;
  logic [OFF_W-1:0] blue_period;
  logic             red_reverse;
  logic             green_reverse;
  logic             blue_reverse;

  logic [OFF_W-1:0]  anim_offset;
  logic [OFF_W-1:0]  red_phase;
  logic [OFF_W-1:0]  green_phase;
  logic [OFF_W-1:0]  blue_phase;
  logic [IW-1:0]     red_centre;
  logic [IW-1:0]     green_centre;
  logic [IW-1:0]     blue_centre;
  logic [7:0]        intensity;
  logic              dimmer_previous;
  logic              brighter_previous;
  logic [SYNC_W-1:0] sync_cnt;

  logic              accept;
  logic              held;
  logic              red_move;
  logic              green_move;
  logic              blue_move;
  logic              wrap;
  logic [7:0]        intensity_next;
  logic [OFF_W-1:0]  anim_offset_next;
  logic [OFF_W-1:0]  red_phase_next;
  logic [OFF_W-1:0]  green_phase_next;
  logic [OFF_W-1:0]  blue_phase_next;
  logic [IW-1:0]     red_centre_next;
  logic [IW-1:0]     green_centre_next;
  logic [IW-1:0]     blue_centre_next;
  logic              sync_bit;

  function automatic logic [IW-1:0] move_centre(input logic [IW-1:0] c,
                                                input logic          reverse);
    logic [IW-1:0] res;
    if (reverse) begin
      res = (c == '0) ? IW'(RING_PIXELS - 1) : c - IW'(1);
    end else begin
      res = (c == IW'(RING_PIXELS - 1)) ? '0 : c + IW'(1);
    end
    return res;
  endfunction

  function automatic logic [OFF_W-1:0] phase_step(input logic [OFF_W-1:0] ph,
                                                  input logic [OFF_W-1:0] period);
    logic [OFF_W:0] inc;
    inc = {1'b0, ph} + (OFF_W+1)'(1);
    return (inc == {1'b0, period}) ? '0 : inc[OFF_W-1:0];
  endfunction

  // no tick while a register is written or the phases are being realigned
  assign tick_ready = (sync_cnt == '0) && !cfg_write && job_ready;
  assign accept     = tick_valid && tick_ready;
  assign held       = tick.dimmer_pressed || tick.brighter_pressed;

  always_comb begin
    intensity_next = intensity;
    if (tick.dimmer_pressed && !dimmer_previous &&
        intensity >= 8'(LEVEL_MIN + STEP)) begin
      intensity_next = intensity - 8'(STEP);
    end else if (tick.brighter_pressed && !brighter_previous &&
                 ({1'b0, intensity} + 9'(STEP)) <= 9'(LEVEL_MAX)) begin
      intensity_next = intensity + 8'(STEP);
    end
  end

  assign red_move   = (red_phase == '0);
  assign green_move = (green_phase == '0);
  assign blue_move  = (blue_phase == '0);

  assign red_centre_next   = red_move ? move_centre(red_centre, red_reverse) : red_centre;
  assign green_centre_next = green_move ? move_centre(green_centre, green_reverse)
                                        : green_centre;
  assign blue_centre_next  = blue_move ? move_centre(blue_centre, blue_reverse)
                                       : blue_centre;

  assign wrap             = ({1'b0, anim_offset} + (OFF_W+1)'(1)) >= {1'b0, cycle_length};
  assign anim_offset_next = wrap ? '0 : anim_offset + OFF_W'(1);
  assign red_phase_next   = wrap ? '0 : phase_step(red_phase, red_period);
  assign green_phase_next = wrap ? '0 : phase_step(green_phase, green_period);
  assign blue_phase_next  = wrap ? '0 : phase_step(blue_phase, blue_period);

  assign job_valid        = accept && (held || red_move || green_move || blue_move);
  assign job.bar          = held;
  assign job.level        = intensity_next;
  assign job_red_centre   = red_centre_next;
  assign job_green_centre = green_centre_next;
  assign job_blue_centre  = blue_centre_next;

  // offset bits msb first during realignment
  assign sync_bit = anim_offset[3'(sync_cnt - SYNC_W'(1))];

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_length      <= OFF_W'(CYCLE_RESET);
      red_period        <= OFF_W'(RED_PER_RESET);
      green_period      <= OFF_W'(GREEN_PER_RESET);
      blue_period       <= OFF_W'(BLUE_PER_RESET);
      red_reverse       <= 1'b0;
      green_reverse     <= 1'b0;
      blue_reverse      <= 1'b0;
      anim_offset       <= '0;
      red_phase         <= '0;
      green_phase       <= '0;
      blue_phase        <= '0;
      red_centre        <= IW'(RED_CENTRE_RESET);
      green_centre      <= IW'(GREEN_CENTRE_RESET);
      blue_centre       <= IW'(BLUE_CENTRE_RESET);
      intensity         <= 8'(LEVEL_RESET);
      dimmer_previous   <= 1'b0;
      brighter_previous <= 1'b0;
      sync_cnt          <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CYCLE_LENGTH:  cycle_length  <= cfg_data;
        REG_RED_PERIOD:    red_period    <= cfg_data;
        REG_GREEN_PERIOD:  green_period  <= cfg_data;
        REG_BLUE_PERIOD:   blue_period   <= cfg_data;
        REG_RED_REVERSE:   red_reverse   <= cfg_data[0];
        REG_GREEN_REVERSE: green_reverse <= cfg_data[0];
        REG_BLUE_REVERSE:  blue_reverse  <= cfg_data[0];
        default: ;
      endcase
      // restart offset modulo period for all three bands
      red_phase   <= '0;
      green_phase <= '0;
      blue_phase  <= '0;
      sync_cnt    <= SYNC_W'(OFF_W);
    end else if (sync_cnt != '0) begin
      red_phase   <= lrba_rem_step(red_phase, sync_bit, red_period);
      green_phase <= lrba_rem_step(green_phase, sync_bit, green_period);
      blue_phase  <= lrba_rem_step(blue_phase, sync_bit, blue_period);
      sync_cnt    <= sync_cnt - SYNC_W'(1);
    end else if (accept) begin
      intensity         <= intensity_next;
      dimmer_previous   <= tick.dimmer_pressed;
      brighter_previous <= tick.brighter_pressed;
      if (!held) begin
        red_centre   <= red_centre_next;
        green_centre <= green_centre_next;
        blue_centre  <= blue_centre_next;
        anim_offset  <= anim_offset_next;
        red_phase    <= red_phase_next;
        green_phase  <= green_phase_next;
        blue_phase   <= blue_phase_next;
      end
    end
  end

endmodule

### sv/lrba_frame_gen.sv
// ----------------------------------------------------------------------------
// lrba_frame_gen
// Holds one frame request and emits its pixels into the output register, one
// per cycle while not stalled, as a level bar or as three colour bands.
// ----------------------------------------------------------------------------
module lrba_frame_gen
  import lrba_pkg::*;
#(
  parameter int RING_PIXELS = RING_PIXELS_DEFAULT,
  parameter int BAND_SPAN   = BAND_SPAN_DEFAULT,
  localparam int IW = $clog2(RING_PIXELS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  lrba_job_t     job,
  input  logic [IW-1:0] job_red_centre,
  input  logic [IW-1:0] job_green_centre,
  input  logic [IW-1:0] job_blue_centre,
  output logic          pixel_valid,
  input  logic          pixel_ready,
  output lrba_pixel_t   pixel
);

  localparam int STEP  = (LEVEL_MAX - LEVEL_MIN) / RING_PIXELS;
  localparam int HALF  = (BAND_SPAN - 1) / 2;
  localparam int BAR_W = 12;

  logic          busy;
  lrba_job_t     cur;
  logic [IW-1:0] red_centre;
  logic [IW-1:0] green_centre;
  logic [IW-1:0] blue_centre;
  logic [IW-1:0] pix;

  logic          emit;
  logic          last_pix;
  logic          bar_lit;
  lrba_pixel_t   pixel_next;

  function automatic logic [7:0] band_value(input logic [IW-1:0] p,
                                            input logic [IW-1:0] c,
                                            input logic [7:0]    lvl);
    logic [IW:0] s;
    logic [IW:0] d;
    logic [IW:0] dn;
    logic [7:0]  res;
    s  = {1'b0, p} + (IW+1)'(RING_PIXELS) - {1'b0, c};
    d  = (s >= (IW+1)'(RING_PIXELS)) ? s - (IW+1)'(RING_PIXELS) : s;
    dn = (IW+1)'(RING_PIXELS) - d;
    if (dn < d) begin
      d = dn;
    end
    res = (d <= (IW+1)'(HALF)) ? lrba_band_level(lvl, 3'(d)) : 8'd0;
    return res;
  endfunction

  assign emit      = busy && (!pixel_valid || pixel_ready);
  assign last_pix  = (pix == IW'(RING_PIXELS - 1));
  assign job_ready = !busy || (emit && last_pix);

  // pixel i is lit while i * step stays within intensity above the floor
  assign bar_lit = (BAR_W'(pix) * BAR_W'(STEP)) <= BAR_W'(cur.level - 8'(LEVEL_MIN));

  always_comb begin
    pixel_next.pixel_index = pix[3:0];
    pixel_next.last        = last_pix;
    if (cur.bar) begin
      pixel_next.red   = bar_lit ? cur.level : 8'd0;
      pixel_next.green = bar_lit ? cur.level : 8'd0;
      pixel_next.blue  = bar_lit ? cur.level : 8'd0;
    end else begin
      pixel_next.red   = band_value(pix, red_centre, cur.level);
      pixel_next.green = band_value(pix, green_centre, cur.level);
      pixel_next.blue  = band_value(pix, blue_centre, cur.level);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pix         <= '0;
      pixel_valid <= 1'b0;
    end else begin
      if (emit) begin
        pixel_valid <= 1'b1;
        pix         <= last_pix ? '0 : pix + IW'(1);
        if (last_pix) begin
          busy <= 1'b0;
        end
      end else if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end
      if (job_valid) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel <= pixel_next;
    end
    if (job_valid) begin
      cur          <= job;
      red_centre   <= job_red_centre;
      green_centre <= job_green_centre;
      blue_centre  <= job_blue_centre;
    end
  end

endmodule

### sv/led_ring_band_animator.sv
// ----------------------------------------------------------------------------
// led_ring_band_animator
// Button-driven intensity control and red/green/blue band animation for a
// ring of RGB pixels; one tick in, up to one frame of pixel words out.
// ----------------------------------------------------------------------------
// a frame request is registered, then each pixel word in the output register
// a frame is RING_PIXELS words at one word per cycle while pixel_ready is high;
//   the next tick waits until the last word of a frame is emitted
// a configuration write realigns the band phases bit by bit; ticks wait
// reset: intensity 128, centres 0/4/8, offset and phases zero, defaults loaded
module led_ring_band_animator
  import lrba_pkg::*;
#(
  parameter int RING_PIXELS = RING_PIXELS_DEFAULT,
  parameter int BAND_SPAN   = BAND_SPAN_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick_valid,
  output logic                 tick_ready,
  input  lrba_tick_t           tick,
  output logic                 pixel_valid,
  input  logic                 pixel_ready,
  output lrba_pixel_t          pixel,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IW = $clog2(RING_PIXELS);

  logic          job_valid;
  logic          job_ready;
  lrba_job_t     job;
  logic [IW-1:0] job_red_centre;
  logic [IW-1:0] job_green_centre;
  logic [IW-1:0] job_blue_centre;

  lrba_tick_state #(
    .RING_PIXELS(RING_PIXELS)
  ) u_tick_state (
    .clk              (clk),
    .rst              (rst),
    .tick_valid       (tick_valid),
    .tick_ready       (tick_ready),
    .tick             (tick),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .job_valid        (job_valid),
    .job_ready        (job_ready),
    .job              (job),
    .job_red_centre   (job_red_centre),
    .job_green_centre (job_green_centre),
    .job_blue_centre  (job_blue_centre)
  );

  lrba_frame_gen #(
    .RING_PIXELS(RING_PIXELS),
    .BAND_SPAN  (BAND_SPAN)
  ) u_frame_gen (
    .clk              (clk),
    .rst              (rst),
    .job_valid        (job_valid),
    .job_ready        (job_ready),
    .job              (job),
    .job_red_centre   (job_red_centre),
    .job_green_centre (job_green_centre),
    .job_blue_centre  (job_blue_centre),
    .pixel_valid      (pixel_valid),
    .pixel_ready      (pixel_ready),
    .pixel            (pixel)
  );

endmodule

### verif/tb_led_ring_band_animator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_ring_band_animator
// Drives button ticks and register settings into the ring animator, predicts
// every level-bar and band frame, and checks each pixel word in order; both
// handshakes idle and stall at random in all but the last two phases.
// ----------------------------------------------------------------------------
module tb_led_ring_band_animator;
  import lrba_pkg::*;

  localparam int RING        = RING_PIXELS_DEFAULT;
  localparam int HALF_SPAN   = (BAND_SPAN_DEFAULT - 1) / 2;
  localparam int STEP_SIZE   = (LEVEL_MAX - LEVEL_MIN) / RING;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 55;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {LEAN_NONE, LEAN_BRIGHTER, LEAN_DIMMER} button_lean_e;

  class frame_scoreboard;
    logic [5:0]  cycle_length, red_period, green_period, blue_period;
    logic        red_reverse, green_reverse, blue_reverse;
    logic [5:0]  offset;
    int          red_centre, green_centre, blue_centre;
    int          level;
    logic        dimmer_was, brighter_was;
    lrba_pixel_t pending_pixels[$];
    int          mismatches;

    function new();
      cycle_length  = 6'(CYCLE_RESET);
      red_period    = 6'(RED_PER_RESET);
      green_period  = 6'(GREEN_PER_RESET);
      blue_period   = 6'(BLUE_PER_RESET);
      red_reverse   = 1'b0;
      green_reverse = 1'b0;
      blue_reverse  = 1'b0;
      offset        = '0;
      red_centre    = RED_CENTRE_RESET;
      green_centre  = GREEN_CENTRE_RESET;
      blue_centre   = BLUE_CENTRE_RESET;
      level         = LEVEL_RESET;
      dimmer_was    = 1'b0;
      brighter_was  = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CYCLE_LENGTH:  cycle_length  = data;
        REG_RED_PERIOD:    red_period    = data;
        REG_GREEN_PERIOD:  green_period  = data;
        REG_BLUE_PERIOD:   blue_period   = data;
        REG_RED_REVERSE:   red_reverse   = data[0];
        REG_GREEN_REVERSE: green_reverse = data[0];
        REG_BLUE_REVERSE:  blue_reverse  = data[0];
        default: ;
      endcase
    endfunction

    // a zero period only matches offset zero
    function bit period_hit(logic [5:0] off, logic [5:0] period);
      if (period == '0) return off == '0;
      return (off % period) == '0;
    endfunction

    function int moved_centre(int centre, logic reverse);
      return reverse ? (centre + RING - 1) % RING : (centre + 1) % RING;
    endfunction

    function logic [7:0] band_value(int centre, int pos);
      int fwd, back, gap;
      fwd  = (pos - centre + RING) % RING;
      back = (centre - pos + RING) % RING;
      gap  = (fwd < back) ? fwd : back;
      if (gap > HALF_SPAN) return 8'd0;
      return 8'(level / (gap + 1));
    endfunction

    function void queue_pixel(int i, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      lrba_pixel_t p;
      p.pixel_index = 4'(i);
      p.red         = r;
      p.green       = g;
      p.blue        = b;
      p.last        = (i == RING - 1);
      pending_pixels.push_back(p);
    endfunction

    function void note_tick(lrba_tick_t t);
      int         top;
      bit         moved;
      logic [5:0] off;
      logic [7:0] v;
      // dimmer wins when both rise, unless it is already at the floor
      if (t.dimmer_pressed && !dimmer_was && level >= LEVEL_MIN + STEP_SIZE)
        level -= STEP_SIZE;
      else if (t.brighter_pressed && !brighter_was && level + STEP_SIZE <= LEVEL_MAX)
        level += STEP_SIZE;
      dimmer_was   = t.dimmer_pressed;
      brighter_was = t.brighter_pressed;

      if (t.dimmer_pressed || t.brighter_pressed) begin
        top = (level - LEVEL_MIN) / STEP_SIZE;
        for (int i = 0; i < RING; i++) begin
          v = (i <= top) ? 8'(level) : 8'd0;
          queue_pixel(i, v, v, v);
        end
        return;
      end

      off   = offset;
      moved = 1'b0;
      if (period_hit(off, red_period)) begin
        red_centre = moved_centre(red_centre, red_reverse);
        moved = 1'b1;
      end
      if (period_hit(off, green_period)) begin
        green_centre = moved_centre(green_centre, green_reverse);
        moved = 1'b1;
      end
      if (period_hit(off, blue_period)) begin
        blue_centre = moved_centre(blue_centre, blue_reverse);
        moved = 1'b1;
      end
      offset = (int'(off) + 1 >= int'(cycle_length)) ? 6'd0 : off + 6'd1;
      if (!moved) return;
      for (int i = 0; i < RING; i++)
        queue_pixel(i, band_value(red_centre, i), band_value(green_centre, i),
                    band_value(blue_centre, i));
    endfunction

    function void check_pixel(lrba_pixel_t got);
      lrba_pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("pixel word %0d arrived with no frame pending", got.pixel_index);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_index !== want.pixel_index) begin
        $error("pixel_index: expected %0d, got %0d", want.pixel_index, got.pixel_index);
        mismatches++;
      end
      if (got.red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst         = 1'b1;
  logic                 tick_valid  = 1'b0;
  logic                 tick_ready;
  lrba_tick_t           tick        = '0;
  logic                 pixel_valid;
  logic                 pixel_ready = 1'b0;
  lrba_pixel_t          pixel;
  logic                 cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]     cfg_data    = '0;

  frame_scoreboard sb = new();
  int send_idle_pct  = 20;
  int recv_stall_pct = 62;

  led_ring_band_animator dut (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (tick_valid),
    .tick_ready  (tick_ready),
    .tick        (tick),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      pixel_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && pixel_valid && pixel_ready) sb.check_pixel(pixel);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((tick_valid && tick_ready) || (pixel_valid && pixel_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[led_ring_band_animator] ERROR");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_tick(input lrba_tick_t t, input bit drain_first);
    if (drain_first || $urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(negedge clk);
      if (drain_first) begin
        while (sb.pending_pixels.size() != 0) @(negedge clk);
      end else begin
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
      end
    end
    tick_valid <= 1'b1;
    tick       <= t;
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
    sb.note_tick(t);
    @(negedge clk);
  endtask

  task automatic press(input logic dimmer, input logic brighter);
    lrba_tick_t t;
    t.dimmer_pressed   = dimmer;
    t.brighter_pressed = brighter;
    send_tick(t, 1'b0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_register(idx, data);
    @(negedge clk);
  endtask

  // only written once the block has gone quiet
  task automatic apply_setting(input logic [5:0] cyc, input logic [5:0] red_per,
                               input logic [5:0] green_per, input logic [5:0] blue_per,
                               input logic [5:0] red_rev, input logic [5:0] green_rev,
                               input logic [5:0] blue_rev);
    tick_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    write_register(REG_CYCLE_LENGTH, cyc);
    write_register(REG_RED_PERIOD, red_per);
    write_register(REG_GREEN_PERIOD, green_per);
    write_register(REG_BLUE_PERIOD, blue_per);
    write_register(REG_RED_REVERSE, red_rev);
    write_register(REG_GREEN_REVERSE, green_rev);
    write_register(REG_BLUE_REVERSE, blue_rev);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic lrba_tick_t random_tick(button_lean_e lean);
    lrba_tick_t t;
    int         r;
    t = '0;
    r = $urandom_range(99);
    if (r < 50) return t;
    case (lean)
      LEAN_BRIGHTER: begin
        t.brighter_pressed = (r < 85) || (r >= 93);
        t.dimmer_pressed   = (r >= 85);
      end
      LEAN_DIMMER: begin
        t.dimmer_pressed   = (r < 85) || (r >= 93);
        t.brighter_pressed = (r >= 85);
      end
      default: begin
        t.dimmer_pressed   = (r < 67) || (r >= 84);
        t.brighter_pressed = (r >= 67);
      end
    endcase
    return t;
  endfunction

  initial begin
    button_lean_e lean;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // offset zero moves all three bands
    press(1'b0, 1'b0);
    // walk the level down to the floor
    repeat (7) begin
      press(1'b1, 1'b0);
      press(1'b0, 1'b0);
    end
    press(1'b1, 1'b0);
    press(1'b0, 1'b0);
    // both rise at the floor: brighter steps instead
    press(1'b1, 1'b1);
    press(1'b0, 1'b0);
    // both rise above the floor: dimmer steps
    press(1'b1, 1'b1);
    press(1'b1, 1'b1);
    press(1'b0, 1'b1);
    press(1'b0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct  = 62;
        recv_stall_pct = 20;
      end
      if (p == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case (p)
        0: ;
        1: apply_setting(6'd63, 6'd1, 6'd2, 6'd3, 6'd1, 6'd0, 6'd1);
        2: apply_setting(6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd1, 6'd0);
        // upper data bits of the direction registers must be dropped
        3: apply_setting(6'd40, 6'd63, 6'd7, 6'd0, 6'h3f, 6'h3e, 6'h01);
        // short cycle after a long one leaves the offset past the wrap
        4: apply_setting(6'd5, 6'd1, 6'd5, 6'd4, 6'd0, 6'd0, 6'd0);
        default: apply_setting(6'($urandom_range(63)), 6'($urandom_range(63)),
                               6'($urandom_range(63)), 6'($urandom_range(63)),
                               6'($urandom_range(63)), 6'($urandom_range(63)),
                               6'($urandom_range(63)));
      endcase
      lean = button_lean_e'(p % 3);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_tick(random_tick(lean), (p == 1 && n == 20) || $urandom_range(59) == 0);
    end

    tick_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending_pixels.size() != 0) begin
      $error("%0d pixel words never arrived", sb.pending_pixels.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("[led_ring_band_animator] OK");
    end else begin
      $display("[led_ring_band_animator] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/lrba_pkg.sv
sv/lrba_tick_state.sv
sv/lrba_frame_gen.sv
sv/led_ring_band_animator.sv
verif/tb_led_ring_band_animator.sv
